FILE: hdl/cmfuv_pkg.sv
// ============================================================================
// cmfuv_pkg
// Shared types and constants for the cube map face and UV block: component
// and coordinate widths, face codes and the transaction payload structs.
// ============================================================================
package cmfuv_pkg;

  // Width of one signed direction component.
  localparam int COMP_BITS  = 16;
  // Width of one unsigned face coordinate (Q0.COORD_BITS).
  localparam int COORD_BITS = 16;

  // Face codes.
  typedef enum logic [2:0] {
    FACE_POS_Z = 3'd0,
    FACE_NEG_Z = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_X = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Y = 3'd5
  } face_t;

  // Input transaction: one direction vector.
  typedef struct packed {
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
  } dir_t;

  // Output transaction: selected face and its texture coordinates.
  typedef struct packed {
    face_t                 face;
    logic [COORD_BITS-1:0] coord_u;
    logic [COORD_BITS-1:0] coord_v;
    logic                  invalid;
  } face_uv_t;

endpackage

FILE: hdl/cube_map_face_uv_core.sv
// ============================================================================
// cube_map_face_uv_core
// Picks the major-axis cube face of a direction vector and computes the
// face texture coordinates u and v with a one-bit-per-stage divider.
// ============================================================================
//
// Usage:
//   The vec channel (vec_valid, vec_ready, vec) takes one direction vector
//   per transaction; the res channel (res_valid, res_ready, res) returns one
//   face code with coordinates u and v and an invalid flag per vector, in
//   order. A zero vector returns face -z, u = v = 0 and invalid set.
//   Stages: the first stage selects the face, the major magnitude and the
//   two numerators; each of the next COORD_BITS stages produces one
//   quotient bit of u and of v. The result is driven from the registers of
//   the last stage without a further register.
//   Throughput: one transaction per cycle, sustained while res_ready is high,
//   set by each stage's restoring divide step, on a different vector each cycle.
//   Stalls: every stage has its own valid bit and accepts a new transaction
//   whenever it is empty or its content moves on, so bubbles are squeezed
//   out while res_ready is low and up to COORD_BITS + 1 results are held.
//   Reset: rst clears all valid bits; the block is empty and ready at once.
//
module cube_map_face_uv_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                vec_valid,
  output logic                vec_ready,
  input  cmfuv_pkg::dir_t     vec,
  output logic                res_valid,
  input  logic                res_ready,
  output cmfuv_pkg::face_uv_t res
);

  localparam int CB = cmfuv_pkg::COMP_BITS;
  localparam int CW = cmfuv_pkg::COORD_BITS;
  // Face select stage plus one stage per quotient bit.
  localparam int NS = CW + 1;

  // Per-stage control and payload registers.
  logic                   vld   [NS];
  logic                   rdy   [NS];
  cmfuv_pkg::face_t       face  [NS];
  logic                   inval [NS];
  logic                   sat_u [NS];
  logic                   sat_v [NS];
  logic [CB:0]            den   [NS];
  logic [CB:0]            rem_u [NS];
  logic [CB:0]            rem_v [NS];
  logic [CW-1:0]          quo_u [NS];
  logic [CW-1:0]          quo_v [NS];

  // Face selection signals for the first stage.
  logic [CB-1:0]          mag_x, mag_y, mag_z;
  logic                   pos_x, pos_y, pos_z;
  logic signed [CB:0]     ext_x, ext_y, ext_z;
  logic [CB-1:0]          major;
  logic signed [CB:0]     s_sel, t_sel;
  cmfuv_pkg::face_t       face_sel;
  logic signed [CB+1:0]   num_u_wide, num_v_wide;
  logic [CB:0]            num_u, num_v, den_sel;

  // Ready chain: a stage can load when it is empty or its content leaves.
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || res_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign vec_ready = rdy[0];

  // Magnitudes, signs and major axis selection.
  always_comb begin
    ext_x = {vec.dir_x[CB-1], vec.dir_x};
    ext_y = {vec.dir_y[CB-1], vec.dir_y};
    ext_z = {vec.dir_z[CB-1], vec.dir_z};
    mag_x = vec.dir_x[CB-1] ? (~vec.dir_x + 1'b1) : vec.dir_x;
    mag_y = vec.dir_y[CB-1] ? (~vec.dir_y + 1'b1) : vec.dir_y;
    mag_z = vec.dir_z[CB-1] ? (~vec.dir_z + 1'b1) : vec.dir_z;
    pos_x = !vec.dir_x[CB-1] && (vec.dir_x != '0);
    pos_y = !vec.dir_y[CB-1] && (vec.dir_y != '0);
    pos_z = !vec.dir_z[CB-1] && (vec.dir_z != '0);

    if ((mag_x > mag_y) && (mag_x > mag_z)) begin
      major    = mag_x;
      face_sel = pos_x ? cmfuv_pkg::FACE_POS_X : cmfuv_pkg::FACE_NEG_X;
      s_sel    = pos_x ? -ext_z : ext_z;
      t_sel    = ext_y;
    end else if (mag_y > mag_z) begin
      major    = mag_y;
      face_sel = pos_y ? cmfuv_pkg::FACE_POS_Y : cmfuv_pkg::FACE_NEG_Y;
      s_sel    = ext_x;
      t_sel    = pos_y ? -ext_z : ext_z;
    end else begin
      major    = mag_z;
      face_sel = pos_z ? cmfuv_pkg::FACE_POS_Z : cmfuv_pkg::FACE_NEG_Z;
      s_sel    = pos_z ? ext_x : -ext_x;
      t_sel    = ext_y;
    end

    // Numerators lie in [0, 2m]; the divisor is 2m.
    num_u_wide = $signed({2'b00, major}) + $signed({s_sel[CB], s_sel});
    num_v_wide = $signed({2'b00, major}) - $signed({t_sel[CB], t_sel});
    num_u      = num_u_wide[CB:0];
    num_v      = num_v_wide[CB:0];
    den_sel    = {major, 1'b0};
  end

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld[0] <= vec_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // First stage payload: face, divisor and numerators.
  always_ff @(posedge clk) begin
    if (rdy[0] && vec_valid) begin
      face[0]  <= face_sel;
      inval[0] <= (major == '0);
      sat_u[0] <= (num_u == den_sel);
      sat_v[0] <= (num_v == den_sel);
      den[0]   <= den_sel;
      rem_u[0] <= num_u;
      rem_v[0] <= num_v;
      quo_u[0] <= '0;
      quo_v[0] <= '0;
    end
  end

  // Divide stages: each produces one quotient bit of u and of v.
  for (genvar k = 1; k < NS; k++) begin : g_div
    logic [CB+1:0] dbl_u, dbl_v, dif_u, dif_v;
    logic          bit_u, bit_v;

    always_comb begin
      dbl_u = {rem_u[k-1], 1'b0};
      dbl_v = {rem_v[k-1], 1'b0};
      dif_u = dbl_u - {1'b0, den[k-1]};
      dif_v = dbl_v - {1'b0, den[k-1]};
      bit_u = (dbl_u >= {1'b0, den[k-1]});
      bit_v = (dbl_v >= {1'b0, den[k-1]});
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        face[k]  <= face[k-1];
        inval[k] <= inval[k-1];
        sat_u[k] <= sat_u[k-1];
        sat_v[k] <= sat_v[k-1];
        den[k]   <= den[k-1];
        rem_u[k] <= bit_u ? dif_u[CB:0] : dbl_u[CB:0];
        rem_v[k] <= bit_v ? dif_v[CB:0] : dbl_v[CB:0];
        quo_u[k] <= {quo_u[k-1][CW-2:0], bit_u};
        quo_v[k] <= {quo_v[k-1][CW-2:0], bit_v};
      end
    end
  end

  // Result: a zero vector gives zero coordinates, exactly 1.0 saturates.
  always_comb begin
    res_valid   = vld[NS-1];
    res.face    = face[NS-1];
    res.invalid = inval[NS-1];
    if (inval[NS-1]) begin
      res.coord_u = '0;
      res.coord_v = '0;
    end else begin
      res.coord_u = sat_u[NS-1] ? {CW{1'b1}} : quo_u[NS-1];
      res.coord_v = sat_v[NS-1] ? {CW{1'b1}} : quo_v[NS-1];
    end
  end

endmodule

FILE: bench/tb_cube_map_face_uv_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_cube_map_face_uv_core
// Self-checking bench for the cube map face and UV block. Direction vectors
// are driven on the vec channel, and each one's face, u, v and invalid flag
// are predicted in the bench. Every res transaction is checked in order
// against that prediction. The run goes through directed corner vectors and
// then random vectors under several sender idle and receiver stall mixes.
// ============================================================================
module tb_cube_map_face_uv_core;

  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 410;

  // Predicts face codes and coordinates and holds them until the matching
  // result transaction arrives.
  class face_uv_scoreboard;
    cmfuv_pkg::face_uv_t expected_face_uv[$];
    int                  mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Fraction num / (2m) in Q0.COORD_BITS, truncated and saturated at 1.0.
    static function logic [cmfuv_pkg::COORD_BITS-1:0] scale_frac(longint num, longint m);
      longint q;
      longint max_code;
      max_code = (longint'(1) << cmfuv_pkg::COORD_BITS) - 1;
      if (num < 0) begin
        num = 0;
      end
      q = (num << cmfuv_pkg::COORD_BITS) / (2 * m);
      if (q > max_code) begin
        q = max_code;
      end
      return q[cmfuv_pkg::COORD_BITS-1:0];
    endfunction

    static function cmfuv_pkg::face_uv_t predict_face_uv(cmfuv_pkg::dir_t d);
      longint              x, y, z, ax, ay, az, m, s, t;
      cmfuv_pkg::face_uv_t r;
      x  = $signed(d.dir_x);
      y  = $signed(d.dir_y);
      z  = $signed(d.dir_z);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      // Strict compares in x, y, z order: ties fall to the later axis.
      if (ax > ay && ax > az) begin
        m = ax;
        t = y;
        if (x > 0) begin
          r.face = cmfuv_pkg::FACE_POS_X;
          s = -z;
        end else begin
          r.face = cmfuv_pkg::FACE_NEG_X;
          s = z;
        end
      end else if (ay > az) begin
        m = ay;
        s = x;
        if (y > 0) begin
          r.face = cmfuv_pkg::FACE_POS_Y;
          t = -z;
        end else begin
          r.face = cmfuv_pkg::FACE_NEG_Y;
          t = z;
        end
      end else begin
        m = az;
        t = y;
        if (z > 0) begin
          r.face = cmfuv_pkg::FACE_POS_Z;
          s = x;
        end else begin
          r.face = cmfuv_pkg::FACE_NEG_Z;
          s = -x;
        end
      end
      // A zero vector has no major axis and is flagged instead of divided.
      if (m == 0) begin
        r.coord_u = '0;
        r.coord_v = '0;
        r.invalid = 1'b1;
      end else begin
        r.coord_u = scale_frac(m + s, m);
        r.coord_v = scale_frac(m - t, m);
        r.invalid = 1'b0;
      end
      return r;
    endfunction

    function void note_vector(cmfuv_pkg::dir_t d);
      expected_face_uv.push_back(predict_face_uv(d));
    endfunction

    function void check_face_uv(cmfuv_pkg::face_uv_t got);
      cmfuv_pkg::face_uv_t want;
      if (expected_face_uv.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result face %0d u %0d v %0d invalid %0b",
                   $realtime, got.face, got.coord_u, got.coord_v, got.invalid);
        end
        return;
      end
      want = expected_face_uv.pop_front();
      if (got.face !== want.face || got.coord_u !== want.coord_u ||
          got.coord_v !== want.coord_v || got.invalid !== want.invalid) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch face %0d/%0d u %0d/%0d v %0d/%0d invalid %0b/%0b (exp/got)",
                   $realtime, want.face, got.face, want.coord_u, got.coord_u,
                   want.coord_v, got.coord_v, want.invalid, got.invalid);
        end
      end
    endfunction

    function int pending();
      return expected_face_uv.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                vec_valid = 1'b0;
  logic                vec_ready;
  cmfuv_pkg::dir_t     vec = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  cmfuv_pkg::face_uv_t res;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  face_uv_scoreboard scoreboard = new();

  cube_map_face_uv_core u_top (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_ready (vec_ready),
    .vec       (vec),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Free-running clock.
  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every accepted result transaction.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      scoreboard.check_face_uv(res);
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic cmfuv_pkg::dir_t make_dir(int x, int y, int z);
    cmfuv_pkg::dir_t d;
    d.dir_x = x[cmfuv_pkg::COMP_BITS-1:0];
    d.dir_y = y[cmfuv_pkg::COMP_BITS-1:0];
    d.dir_z = z[cmfuv_pkg::COMP_BITS-1:0];
    return d;
  endfunction

  // Signed component of a given magnitude; a magnitude of 2^15 only exists
  // as the most negative value.
  function automatic int signed_comp(int mag, bit neg);
    int v;
    v = neg ? -mag : mag;
    if (v > 32767) begin
      v = -32768;
    end
    return v;
  endfunction

  function automatic int extreme_comp();
    int pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  // Random vector drawn from a mix of shapes: full-range values, a chosen major axis
  // with bounded minors, tiny values, magnitude ties, extremes and single-axis vectors.
  function automatic cmfuv_pkg::dir_t random_dir();
    int mode, axis, m;
    int c[3];
    mode = $urandom_range(0, 9);
    axis = $urandom_range(0, 2);
    m    = $urandom_range(0, 32768);
    case (mode)
      0, 1, 2, 3: begin
        for (int i = 0; i < 3; i++) c[i] = signed_comp($urandom_range(0, 32768), 1'($urandom));
      end
      4, 5: begin
        for (int i = 0; i < 3; i++) c[i] = signed_comp($urandom_range(0, m), 1'($urandom));
        c[axis] = signed_comp(m, 1'($urandom));
      end
      6: begin
        for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 8) - 4;
      end
      7: begin
        for (int i = 0; i < 3; i++) c[i] = signed_comp(m, 1'($urandom));
        c[axis] = signed_comp($urandom_range(0, m), 1'($urandom));
      end
      8: begin
        for (int i = 0; i < 3; i++) c[i] = extreme_comp();
      end
      default: begin
        for (int i = 0; i < 3; i++) c[i] = 0;
        c[axis] = signed_comp(m, 1'($urandom));
      end
    endcase
    return make_dir(c[0], c[1], c[2]);
  endfunction

  // Drive one vector transaction; called and returns at a falling edge.
  task automatic send_dir(cmfuv_pkg::dir_t d);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      vec_valid <= 1'b0;
      @(negedge clk);
    end
    vec_valid <= 1'b1;
    vec       <= d;
    @(posedge clk);
    while (!vec_ready) begin
      @(negedge clk);
      @(posedge clk);
    end
    scoreboard.note_vector(d);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been returned.
  task automatic drain_results();
    vec_valid <= 1'b0;
    while (scoreboard.pending() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (PHASE_ITEMS) send_dir(random_dir());
    drain_results();
  endtask

  initial begin
    cmfuv_pkg::dir_t directed[$];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero vector, one vector per face, extremes, ties and the u/v limits.
    directed.push_back(make_dir(0, 0, 0));
    directed.push_back(make_dir(0, 0, 100));
    directed.push_back(make_dir(0, 0, -100));
    directed.push_back(make_dir(100, 0, 0));
    directed.push_back(make_dir(-100, 0, 0));
    directed.push_back(make_dir(0, 100, 0));
    directed.push_back(make_dir(0, -100, 0));
    directed.push_back(make_dir(32767, 32767, 32767));
    directed.push_back(make_dir(-32768, -32768, -32768));
    directed.push_back(make_dir(-32768, 32767, 0));
    directed.push_back(make_dir(32767, -32768, 0));
    directed.push_back(make_dir(0, 0, -32768));
    directed.push_back(make_dir(-32768, -32768, 0));
    directed.push_back(make_dir(5, -5, 3));
    directed.push_back(make_dir(7, 0, -7));
    directed.push_back(make_dir(0, 9, 9));
    directed.push_back(make_dir(1000, -1000, 1000));
    directed.push_back(make_dir(-1000, 1000, 1000));
    directed.push_back(make_dir(-32768, 32767, -32767));
    directed.push_back(make_dir(1, 0, 0));
    directed.push_back(make_dir(-1, 0, 0));
    directed.push_back(make_dir(0, -1, 0));
    directed.push_back(make_dir(0, 0, 1));
    directed.push_back(make_dir(32767, 1, -1));
    foreach (directed[i]) send_dir(directed[i]);
    drain_results();

    // Random traffic under each idle and stall mix.
    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(21, 21);

    // Give any stray result time to show up.
    repeat (cmfuv_pkg::COORD_BITS + 8) @(posedge clk);

    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: cube_map_face_uv_core.f
hdl/cmfuv_pkg.sv
hdl/cube_map_face_uv_core.sv
bench/tb_cube_map_face_uv_core.sv
